// ===== sv/tsw_pkg.sv =====
package tsw_pkg;

    // default sizing handed to the top level
    localparam int DEF_TASK_SLOTS = 16;
    localparam int DEF_TEST_LEDS  = 24;

    // only the first slots are covered by the 16-bit enable mask
    localparam int MASK_BITS = 16;
    localparam int STEP_W    = 5;
    localparam int CFG_IDX_W = 4;

    // command codes
    localparam logic [1:0] CMD_TICK      = 2'd0;
    localparam logic [1:0] CMD_SELF_TEST = 2'd1;
    localparam logic [1:0] CMD_STOP      = 2'd2;
    localparam logic [1:0] CMD_HEARTBEAT = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WD_PERIOD   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_PERIOD  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEC_PERIOD  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HOLD    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_LIMIT  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_MASK    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TASK_MASK   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_REPORT  = 4'd7;

    // register reset values
    localparam logic [15:0] RST_WD_PERIOD  = 16'd10;
    localparam logic [15:0] RST_LED_PERIOD = 16'd50;
    localparam logic [15:0] RST_SEC_PERIOD = 16'd100;
    localparam logic [15:0] RST_KEY_HOLD   = 16'd5;
    localparam logic [7:0]  RST_DEAD_LIMIT = 8'd10;
    localparam logic [15:0] RST_KEY_MASK   = 16'hffff;

    localparam logic [15:0] HOLD_SAT = 16'hffff;
    localparam logic [7:0]  AGE_MAX  = 8'hff;

    typedef struct packed {
        logic load;
        logic age_issue;
        logic xfer;
    } tsw_cmd_t;

    typedef struct packed {
        logic age_start;
        logic age_done;
    } tsw_stat_t;

endpackage

// ===== sv/tsw_ctrl.sv =====
module tsw_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  tsw_pkg::tsw_stat_t stat,
    output tsw_pkg::tsw_cmd_t  cmd
);
    import tsw_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_AGE  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        in_stall       = (state_reg != ST_IDLE);
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.age_start ? ST_AGE : ST_WAIT;
                end
            end
            ST_AGE:
            begin
                cmd.age_issue = 1'b1;
                if (stat.age_done)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                // result moves to the output register once it is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.xfer       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== sv/tsw_dp.sv =====
module tsw_dp #(
    parameter int TASK_SLOTS = tsw_pkg::DEF_TASK_SLOTS,
    parameter int TEST_LEDS  = tsw_pkg::DEF_TEST_LEDS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tsw_pkg::tsw_cmd_t              cmd,
    output tsw_pkg::tsw_stat_t             stat,
    input  logic                           cfg_we,
    input  logic [tsw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                    cfg_data,
    input  logic [1:0]                     command,
    input  logic [7:0]                     key_low,
    input  logic [7:0]                     key_high,
    input  logic [3:0]                     task_index,
    output logic                           watchdog_kick,
    output logic                           led_bank_write,
    output logic [23:0]                    led_bank_pattern,
    output logic                           run_led_write,
    output logic                           run_led_on,
    output logic                           clear_other_leds,
    output logic                           restore_logic_leds,
    output logic                           key_event,
    output logic [15:0]                    key_code,
    output logic                           refresh_stopped,
    output logic                           task_fault,
    output logic [3:0]                     fault_task
);
    import tsw_pkg::*;

    localparam int AGE_SLOTS = (TASK_SLOTS < MASK_BITS) ? TASK_SLOTS : MASK_BITS;
    localparam int AW        = $clog2(TASK_SLOTS);
    localparam int KW        = $clog2(AGE_SLOTS + 1);
    localparam int CW        = $clog2(TASK_SLOTS + 1);
    localparam int XW        = (CW > 4) ? CW : 4;

    typedef struct packed {
        logic        kick;
        logic        bank_wr;
        logic [23:0] bank_pat;
        logic        run_wr;
        logic        run_on;
        logic        clr;
        logic        restore;
        logic        kev;
        logic [15:0] kcode;
        logic        stopped;
        logic        fault;
        logic [3:0]  fault_idx;
    } res_t;

    // configuration
    logic [15:0] wd_period_reg, led_period_reg, sec_period_reg, key_hold_reg;
    logic [7:0]  dead_limit_reg;
    logic [15:0] key_mask_reg, task_mask_reg;
    logic        key_report_reg;

    // supervisor state
    logic [15:0]       kick_phase_reg, kick_phase_next;
    logic [15:0]       blink_phase_reg, blink_phase_next;
    logic [15:0]       sec_phase_reg, sec_phase_next;
    logic              parity_reg, parity_next;
    logic              st_active_reg, st_active_next;
    logic [STEP_W-1:0] st_step_reg, st_step_next;
    logic [15:0]       last_key_reg, last_key_next;
    logic [15:0]       hold_cnt_reg, hold_cnt_next;
    logic              refresh_en_reg, refresh_en_next;
    res_t              res_reg, res_next;
    res_t              out_reg;

    // ageing walk
    logic [KW-1:0]         age_idx_reg, age_idx_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic [3:0]            rd_idx_reg, rd_idx_next;
    logic [7:0]            rd_data_reg;
    logic                  rd_bit_reg;
    logic [TASK_SLOTS-1:0] age_vld_reg;
    logic [7:0]            age_mem [TASK_SLOTS];
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [7:0]            age_cur, age_inc;

    logic [16:0] kick_nx, blink_nx, sec_nx;
    logic [15:0] hold_inc;
    logic        kick_wrap, blink_wrap, sec_wrap;
    logic [15:0] kw;
    logic [XW-1:0] tidx_ext;
    logic        hb_clear;

    assign kick_nx    = {1'b0, kick_phase_reg} + 17'd1;
    assign blink_nx   = {1'b0, blink_phase_reg} + 17'd1;
    assign sec_nx     = {1'b0, sec_phase_reg} + 17'd1;
    assign kick_wrap  = kick_nx >= {1'b0, wd_period_reg};
    assign blink_wrap = blink_nx >= {1'b0, led_period_reg};
    assign sec_wrap   = sec_nx >= {1'b0, sec_period_reg};
    assign kw         = {key_high, key_low} & key_mask_reg;
    // only used below saturation, so it cannot wrap
    assign hold_inc   = hold_cnt_reg + 16'd1;
    assign tidx_ext   = XW'(task_index);
    assign hb_clear   = cmd.load && (command == CMD_HEARTBEAT)
                        && (tidx_ext < XW'(TASK_SLOTS));

    assign stat.age_start = (command == CMD_TICK) && sec_wrap;
    assign stat.age_done  = (age_idx_reg == KW'(AGE_SLOTS)) && !rd_vld_reg;

    assign rd_en   = cmd.age_issue && (age_idx_reg < KW'(AGE_SLOTS));
    assign rd_addr = AW'(age_idx_reg);

    // a slot never written since reset or heartbeat reads as zero
    assign age_cur = rd_bit_reg ? rd_data_reg : 8'd0;
    assign age_inc = (age_cur == AGE_MAX) ? AGE_MAX : age_cur + 8'd1;
    assign wr_en   = rd_vld_reg && task_mask_reg[rd_idx_reg];

    always_comb
    begin
        kick_phase_next  = kick_phase_reg;
        blink_phase_next = blink_phase_reg;
        sec_phase_next   = sec_phase_reg;
        parity_next      = parity_reg;
        st_active_next   = st_active_reg;
        st_step_next     = st_step_reg;
        last_key_next    = last_key_reg;
        hold_cnt_next    = hold_cnt_reg;
        refresh_en_next  = refresh_en_reg;
        res_next         = res_reg;
        age_idx_next     = age_idx_reg;
        rd_vld_next      = 1'b0;
        rd_idx_next      = rd_idx_reg;

        if (cmd.load)
        begin
            res_next     = '0;
            age_idx_next = '0;
            unique case (command)
                CMD_SELF_TEST:
                begin
                    if (!st_active_reg)
                    begin
                        st_active_next   = 1'b1;
                        st_step_next     = '0;
                        res_next.bank_wr = 1'b1;
                    end
                end
                CMD_STOP:
                begin
                    refresh_en_next = 1'b0;
                end
                CMD_HEARTBEAT:
                begin
                    // slot clear goes through the valid bits
                end
                CMD_TICK:
                begin
                    kick_phase_next  = kick_wrap ? 16'd0 : kick_nx[15:0];
                    blink_phase_next = blink_wrap ? 16'd0 : blink_nx[15:0];
                    sec_phase_next   = sec_wrap ? 16'd0 : sec_nx[15:0];
                    res_next.kick    = kick_wrap && refresh_en_reg;

                    if (blink_wrap)
                    begin
                        parity_next = !parity_reg;
                        if (st_active_reg)
                        begin
                            if (st_step_reg >= STEP_W'(TEST_LEDS))
                            begin
                                st_active_next   = 1'b0;
                                res_next.restore = 1'b1;
                            end
                            else
                            begin
                                res_next.bank_wr  = 1'b1;
                                res_next.bank_pat = 24'd1 << st_step_reg;
                                st_step_next      = st_step_reg + STEP_W'(1);
                            end
                        end
                        else
                        begin
                            res_next.run_wr = 1'b1;
                            res_next.run_on = !parity_reg;
                            res_next.clr    = parity_reg;
                        end
                    end

                    if (kw != key_mask_reg)
                    begin
                        if (kw == last_key_reg)
                        begin
                            if (hold_cnt_reg != HOLD_SAT)
                            begin
                                hold_cnt_next = hold_inc[15:0];
                                if (hold_inc[15:0] >= key_hold_reg && key_report_reg)
                                begin
                                    res_next.kev   = 1'b1;
                                    res_next.kcode = last_key_reg;
                                    hold_cnt_next  = HOLD_SAT;
                                end
                            end
                        end
                        else
                        begin
                            last_key_next = kw;
                            hold_cnt_next = '0;
                        end
                    end
                    else
                    begin
                        hold_cnt_next = '0;
                        last_key_next = key_mask_reg;
                    end
                end
            endcase
            res_next.stopped = !refresh_en_next;
        end

        if (rd_en)
        begin
            rd_vld_next  = 1'b1;
            rd_idx_next  = 4'(age_idx_reg);
            age_idx_next = age_idx_reg + KW'(1);
        end

        // slots are walked upward, so the first dead one is the lowest
        if (wr_en && (age_inc > dead_limit_reg))
        begin
            refresh_en_next  = 1'b0;
            res_next.stopped = 1'b1;
            if (!res_reg.fault)
            begin
                res_next.fault     = 1'b1;
                res_next.fault_idx = rd_idx_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wd_period_reg   <= RST_WD_PERIOD;
            led_period_reg  <= RST_LED_PERIOD;
            sec_period_reg  <= RST_SEC_PERIOD;
            key_hold_reg    <= RST_KEY_HOLD;
            dead_limit_reg  <= RST_DEAD_LIMIT;
            key_mask_reg    <= RST_KEY_MASK;
            task_mask_reg   <= '0;
            key_report_reg  <= 1'b1;
            kick_phase_reg  <= '0;
            blink_phase_reg <= '0;
            sec_phase_reg   <= '0;
            parity_reg      <= 1'b0;
            st_active_reg   <= 1'b0;
            st_step_reg     <= '0;
            last_key_reg    <= RST_KEY_MASK;
            hold_cnt_reg    <= '0;
            refresh_en_reg  <= 1'b1;
            age_idx_reg     <= '0;
            rd_vld_reg      <= 1'b0;
            rd_bit_reg      <= 1'b0;
            age_vld_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_WD_PERIOD:  wd_period_reg  <= cfg_data;
                    CFG_LED_PERIOD: led_period_reg <= cfg_data;
                    CFG_SEC_PERIOD: sec_period_reg <= cfg_data;
                    CFG_KEY_HOLD:   key_hold_reg   <= cfg_data;
                    CFG_DEAD_LIMIT: dead_limit_reg <= cfg_data[7:0];
                    CFG_KEY_MASK:   key_mask_reg   <= cfg_data;
                    CFG_TASK_MASK:  task_mask_reg  <= cfg_data;
                    CFG_KEY_REPORT: key_report_reg <= cfg_data[0];
                    default:        ;
                endcase
            end
            kick_phase_reg  <= kick_phase_next;
            blink_phase_reg <= blink_phase_next;
            sec_phase_reg   <= sec_phase_next;
            parity_reg      <= parity_next;
            st_active_reg   <= st_active_next;
            st_step_reg     <= st_step_next;
            last_key_reg    <= last_key_next;
            hold_cnt_reg    <= hold_cnt_next;
            refresh_en_reg  <= refresh_en_next;
            age_idx_reg     <= age_idx_next;
            rd_vld_reg      <= rd_vld_next;
            if (hb_clear)
            begin
                age_vld_reg[tidx_ext[AW-1:0]] <= 1'b0;
            end
            if (wr_en)
            begin
                age_vld_reg[AW'(rd_idx_reg)] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_bit_reg <= age_vld_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            age_mem[AW'(rd_idx_reg)] <= age_inc;
        end
        if (rd_en)
        begin
            rd_data_reg <= age_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        rd_idx_reg <= rd_idx_next;
        if (cmd.xfer)
        begin
            out_reg <= res_reg;
        end
    end

    assign watchdog_kick      = out_reg.kick;
    assign led_bank_write     = out_reg.bank_wr;
    assign led_bank_pattern   = out_reg.bank_pat;
    assign run_led_write      = out_reg.run_wr;
    assign run_led_on         = out_reg.run_on;
    assign clear_other_leds   = out_reg.clr;
    assign restore_logic_leds = out_reg.restore;
    assign key_event          = out_reg.kev;
    assign key_code           = out_reg.kcode;
    assign refresh_stopped    = out_reg.stopped;
    assign task_fault         = out_reg.fault;
    assign fault_task         = out_reg.fault_idx;

endmodule

// ===== sv/tick_supervisor_watchdog_keys_leds_top.sv =====
// a command is computed into the result register and moved to the output
//   register from the wait state; a tick that starts an ageing pass first walks
//   the min(TASK_SLOTS,16) age slots, reading one age entry per cycle
// the input is held off while the controller is busy, until the result moves out
// reset: asynchronous, active low; control registers take defaults and the age
//   valid bits clear at once, so every slot reads as zero with no clearing pass
module tick_supervisor_watchdog_keys_leds_top #(
    parameter int TASK_SLOTS = tsw_pkg::DEF_TASK_SLOTS,
    parameter int TEST_LEDS  = tsw_pkg::DEF_TEST_LEDS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    command,
    input  logic [7:0]                    key_low,
    input  logic [7:0]                    key_high,
    input  logic [3:0]                    task_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          watchdog_kick,
    output logic                          led_bank_write,
    output logic [23:0]                   led_bank_pattern,
    output logic                          run_led_write,
    output logic                          run_led_on,
    output logic                          clear_other_leds,
    output logic                          restore_logic_leds,
    output logic                          key_event,
    output logic [15:0]                   key_code,
    output logic                          refresh_stopped,
    output logic                          task_fault,
    output logic [3:0]                    fault_task,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tsw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data
);
    import tsw_pkg::*;

    tsw_cmd_t  cmd;
    tsw_stat_t stat;

    assign cfg_ready = 1'b1;

    tsw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    tsw_dp #(
        .TASK_SLOTS (TASK_SLOTS),
        .TEST_LEDS  (TEST_LEDS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .cfg_we             (cfg_valid && cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .command            (command),
        .key_low            (key_low),
        .key_high           (key_high),
        .task_index         (task_index),
        .watchdog_kick      (watchdog_kick),
        .led_bank_write     (led_bank_write),
        .led_bank_pattern   (led_bank_pattern),
        .run_led_write      (run_led_write),
        .run_led_on         (run_led_on),
        .clear_other_leds   (clear_other_leds),
        .restore_logic_leds (restore_logic_leds),
        .key_event          (key_event),
        .key_code           (key_code),
        .refresh_stopped    (refresh_stopped),
        .task_fault         (task_fault),
        .fault_task         (fault_task)
    );

endmodule

// ===== sv/tsw_chk.sv =====
module tsw_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        watchdog_kick,
    input logic        led_bank_write,
    input logic [23:0] led_bank_pattern,
    input logic        run_led_write,
    input logic [15:0] key_code,
    input logic        refresh_stopped,
    input logic        task_fault,
    input logic [3:0]  fault_task
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(led_bank_pattern)
        && $stable(key_code) && $stable(fault_task) && $stable(watchdog_kick))
        else $error("stalled result beat changed");

    // refresh stop is permanent until reset
    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && refresh_stopped |=> !out_valid || refresh_stopped)
        else $error("refresh came back after being stopped");

    a_fault_stops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && task_fault |-> refresh_stopped)
        else $error("dead task without refresh stop");

    // run led blink and bank write come from exclusive branches
    a_led_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && run_led_write |-> !led_bank_write && (led_bank_pattern == 24'd0))
        else $error("run led and bank write in one beat");

endmodule

bind tick_supervisor_watchdog_keys_leds_top tsw_chk u_tsw_chk (.*);
